### src/active_list_line_parser_defines.svh
// Assertion macros shared by the active listing line parser RTL.
// Depends on signals named clock and reset in the including module.
`ifndef ACTIVE_LIST_LINE_PARSER_DEFINES_SVH
`define ACTIVE_LIST_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ALP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ALP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/alp_pkg.sv
// Types and constants for the active listing line parser.
// No dependencies; used by every module of the block.
`default_nettype none

package alp_pkg;

   // Output widths of offset/length fields and of mark fields
   localparam int OUT_OFS_BITS = 24;
   localparam int MARK_BITS    = 32;

   // Character codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Line status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [1:0] STAT_NO_HIGH  = 2'd2;
   localparam logic [1:0] STAT_NO_LOW   = 2'd3;

   typedef enum logic [2:0] {
      PH_NAME     = 3'd0,
      PH_HIGH_WS  = 3'd1,
      PH_HIGH_DIG = 3'd2,
      PH_LOW_WS   = 3'd3,
      PH_LOW_DIG  = 3'd4,
      PH_FLAG     = 3'd5,
      PH_SKIP     = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_start;
   } req_type;

   typedef struct packed {
      logic [OUT_OFS_BITS-1:0] name_offset;
      logic [OUT_OFS_BITS-1:0] name_length;
      logic [MARK_BITS-1:0]    high_mark;
      logic [MARK_BITS-1:0]    low_mark;
      logic [7:0]              flag_char;
      logic [1:0]              status;
      logic                    saturated;
   } rsp_type;

endpackage

`default_nettype wire

### src/active_list_line_parser.sv
// Active listing line parser: byte stream in, one record per text line out.
// Depends on alp_pkg, alp_parser, alp_acc10 and the assertion macro header.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) carries one text byte per
//   transaction plus buffer_start, which restarts offset and line state
//   before that byte is parsed.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) carries one record per
//   newline: name offset and length, high and low marks, flag byte, status
//   and a saturation flag. Other bytes produce no transaction.
//   Throughput: one byte per cycle while the rsp channel is not stalled. Each
//   byte is parsed combinationally between the input register and the result
//   register; the decimal accumulate is one multiply-by-ten adder.
//   A newline's record is registered in the result register and is valid on
//   rsp after the byte has passed through the input register.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to the start of a line at offset zero.
//   When rsp_ready is low with a record pending, the byte in the input
//   register waits and req_ready drops, whether or not that byte ends a
//   line; bytes flow again in the cycle rsp_ready returns high.
`default_nettype none
`include "active_list_line_parser_defines.svh"

module active_list_line_parser #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire alp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output alp_pkg::rsp_type      rsp_payload
);
   import alp_pkg::*;

   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   rsp_type rec;
   logic    rec_emit;
   logic    step;

   logic    rsp_err;
   logic    rsp_nospace;
   logic    rsp_marks_zero;

   // Parse the held byte when the result slot can take a record
   assign step      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || step;

   alp_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step),
      .item        (req_ff),
      .record      (rec),
      .record_emit (rec_emit)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         req_valid_ff <= 1'b1;
      end else if (step) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && rec_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && rec_emit) begin
         rsp_ff <= rec;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Record classes for the checks
   assign rsp_err        = rsp_valid_ff && (rsp_ff.status != STAT_OK);
   assign rsp_nospace    = rsp_valid_ff && (rsp_ff.status == STAT_NO_SPACE);
   assign rsp_marks_zero = (rsp_ff.high_mark == '0) && (rsp_ff.low_mark == '0);

   // Checks
   `ALP_ASSERT_NEXT(a_nl_makes_record, step && rec_emit, rsp_valid_ff, "newline gave no record")
   `ALP_ASSERT_NEXT(a_no_extra_record, step && !rec_emit, !rsp_valid_ff, "record without newline")
   `ALP_ASSERT_NOW(a_err_no_flag, rsp_err, rsp_ff.flag_char == 8'd0, "flag set on error record")
   `ALP_ASSERT_NOW(a_nospace_no_marks, rsp_nospace, rsp_marks_zero, "marks set without name space")

endmodule

`default_nettype wire

### src/alp_acc10.sv
// Decimal digit accumulator: acc * 10 + digit, saturating at 32 bits.
// Depends on alp_pkg.
`default_nettype none

module alp_acc10 (
   input  wire logic [alp_pkg::MARK_BITS-1:0] acc,
   input  wire logic [3:0]                    digit,
   output logic      [alp_pkg::MARK_BITS-1:0] result,
   output logic                               overflow
);
   import alp_pkg::*;

   logic [MARK_BITS+3:0] wide;

   // x*10 = x*8 + x*2, one adder tree
   assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (MARK_BITS+4)'(digit);
   assign overflow = |wide[MARK_BITS+3:MARK_BITS];
   assign result   = overflow ? {MARK_BITS{1'b1}} : wide[MARK_BITS-1:0];

endmodule

`default_nettype wire

### src/alp_parser.sv
// Per-byte line parser: phase machine, offsets, accumulators, record build.
// Depends on alp_pkg and alp_acc10.
`default_nettype none

module alp_parser #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire alp_pkg::req_type item,
   output alp_pkg::rsp_type      record,
   output logic                  record_emit
);
   import alp_pkg::*;

   localparam logic [OFFSET_BITS-1:0] NAME_MAX = {OFFSET_BITS{1'b1}};

   // Parse state
   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] line_start_ff, line_start_in;
   logic [OFFSET_BITS-1:0] name_count_ff, name_count_in;
   logic [MARK_BITS-1:0]   high_ff, high_in;
   logic [MARK_BITS-1:0]   low_ff, low_in;
   logic [7:0]             flag_ff, flag_in;
   logic [1:0]             status_ff, status_in;
   logic                   ovf_ff, ovf_in;

   // Values after an optional buffer restart
   phase_type              ph_cur;
   logic [OFFSET_BITS-1:0] offset_cur, line_start_cur, name_cur;
   logic [MARK_BITS-1:0]   high_cur, low_cur;
   logic [7:0]             flag_cur;
   logic [1:0]             status_cur;
   logic                   ovf_cur;

   logic                   is_nl, is_digit, is_blank, sel_low;
   logic [MARK_BITS-1:0]   acc_sel, acc_res;
   logic                   acc_ovf;

   // Restart applies before the byte is parsed
   always_comb begin
      if (item.buffer_start) begin
         ph_cur         = PH_NAME;
         offset_cur     = '0;
         line_start_cur = '0;
         name_cur       = '0;
         high_cur       = '0;
         low_cur        = '0;
         flag_cur       = '0;
         status_cur     = STAT_OK;
         ovf_cur        = 1'b0;
      end else begin
         ph_cur         = phase_ff;
         offset_cur     = offset_ff;
         line_start_cur = line_start_ff;
         name_cur       = name_count_ff;
         high_cur       = high_ff;
         low_cur        = low_ff;
         flag_cur       = flag_ff;
         status_cur     = status_ff;
         ovf_cur        = ovf_ff;
      end
   end

   // Byte classes
   assign is_nl    = (item.data_byte == CH_NL);
   assign is_blank = (item.data_byte == CH_SPACE) || (item.data_byte == CH_TAB);
   assign is_digit = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);

   // One shared accumulator; only one number is being built at a time
   assign sel_low = (ph_cur == PH_LOW_WS) || (ph_cur == PH_LOW_DIG);
   assign acc_sel = sel_low ? low_cur : high_cur;

   alp_acc10 u_acc10 (
      .acc      (acc_sel),
      .digit    (item.data_byte[3:0]),
      .result   (acc_res),
      .overflow (acc_ovf)
   );

   // Next state and record
   always_comb begin
      phase_in      = ph_cur;
      name_count_in = name_cur;
      high_in       = high_cur;
      low_in        = low_cur;
      flag_in       = flag_cur;
      status_in     = status_cur;
      ovf_in        = ovf_cur;
      line_start_in = line_start_cur;
      offset_in     = offset_cur + OFFSET_BITS'(1);
      record_emit   = 1'b0;

      case (ph_cur)
         PH_NAME: begin
            if (item.data_byte == CH_SPACE) begin
               phase_in = PH_HIGH_WS;
            end else if (is_nl) begin
               status_in = STAT_NO_SPACE;
            end else if (name_cur < NAME_MAX) begin
               name_count_in = name_cur + OFFSET_BITS'(1);
            end
         end
         PH_HIGH_WS: begin
            if (is_digit) begin
               high_in  = acc_res;
               ovf_in   = ovf_cur | acc_ovf;
               phase_in = PH_HIGH_DIG;
            end else if (!is_blank) begin
               status_in = STAT_NO_HIGH;
               phase_in  = PH_SKIP;
            end
         end
         PH_HIGH_DIG: begin
            if (is_digit) begin
               high_in = acc_res;
               ovf_in  = ovf_cur | acc_ovf;
            end else if (is_blank) begin
               phase_in = PH_LOW_WS;
            end else begin
               status_in = STAT_NO_LOW;
               phase_in  = PH_SKIP;
            end
         end
         PH_LOW_WS: begin
            if (is_digit) begin
               low_in   = acc_res;
               ovf_in   = ovf_cur | acc_ovf;
               phase_in = PH_LOW_DIG;
            end else if (!is_blank) begin
               status_in = STAT_NO_LOW;
               phase_in  = PH_SKIP;
            end
         end
         PH_LOW_DIG: begin
            if (is_digit) begin
               low_in = acc_res;
               ovf_in = ovf_cur | acc_ovf;
            end else if (!is_nl) begin
               phase_in = PH_FLAG;
            end
         end
         PH_FLAG: begin
            if (!is_nl) begin
               flag_in = item.data_byte;
            end
            phase_in = PH_SKIP;
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      // Record for the line just ended
      record.name_offset = OUT_OFS_BITS'(line_start_cur);
      record.name_length = OUT_OFS_BITS'(name_count_in);
      record.high_mark   = high_in;
      record.low_mark    = low_in;
      record.flag_char   = (status_in != STAT_OK) ? 8'd0 : flag_in;
      record.status      = status_in;
      record.saturated   = ovf_in;

      // Newline closes the line and clears its state
      if (is_nl) begin
         record_emit   = 1'b1;
         phase_in      = PH_NAME;
         name_count_in = '0;
         high_in       = '0;
         low_in        = '0;
         flag_in       = '0;
         status_in     = STAT_OK;
         ovf_in        = 1'b0;
         line_start_in = offset_cur + OFFSET_BITS'(1);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NAME;
         offset_ff     <= '0;
         line_start_ff <= '0;
         name_count_ff <= '0;
         high_ff       <= '0;
         low_ff        <= '0;
         flag_ff       <= '0;
         status_ff     <= STAT_OK;
         ovf_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         line_start_ff <= line_start_in;
         name_count_ff <= name_count_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         flag_ff       <= flag_in;
         status_ff     <= status_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

`default_nettype wire
